/* src/qot_pkg.sv */
// Package for the quad overlap test unit: coordinate widths, item layout,
// and the tables that name the edges and triangles of a quad.
// No dependencies; used by quad_overlap_test_unit.
package qot_pkg;

   localparam int COORD_BITS  = 16;
   localparam int FIELD_W     = 32;
   localparam int NUM_CORNERS = 4;
   localparam int NUM_LINES   = 5;
   localparam int NUM_TRIS    = 2;
   localparam int TRI_EDGES   = 3;
   localparam int REQ_W       = 2 * NUM_CORNERS * FIELD_W;
   localparam int RSP_W       = 8;

   // Difference of two coordinates, product of two differences, and the
   // difference of two products.
   localparam int DIFF_W = COORD_BITS + 1;
   localparam int PROD_W = 2 * DIFF_W;
   localparam int ORI_W  = PROD_W + 1;

   typedef logic [1:0] corner_idx_type;
   typedef logic [2:0] line_idx_type;

   localparam corner_idx_type CORNER_A = 2'd0;
   localparam corner_idx_type CORNER_B = 2'd1;
   localparam corner_idx_type CORNER_C = 2'd2;
   localparam corner_idx_type CORNER_D = 2'd3;

   localparam line_idx_type LINE_AB = 3'd0;
   localparam line_idx_type LINE_BC = 3'd1;
   localparam line_idx_type LINE_CA = 3'd2;
   localparam line_idx_type LINE_AD = 3'd3;
   localparam line_idx_type LINE_DC = 3'd4;

   // Directed edges of a quad: every triangle edge is one of these, taken
   // in its forward direction.
   localparam corner_idx_type LINE_FROM [NUM_LINES] =
      '{CORNER_A, CORNER_B, CORNER_C, CORNER_A, CORNER_D};
   localparam corner_idx_type LINE_TO [NUM_LINES] =
      '{CORNER_B, CORNER_C, CORNER_A, CORNER_D, CORNER_C};

   // Triangle (a,b,c) and triangle (a,d,c) of a quad.
   localparam line_idx_type TRI_LINE [NUM_TRIS][TRI_EDGES] =
      '{'{LINE_AB, LINE_BC, LINE_CA}, '{LINE_AD, LINE_DC, LINE_CA}};
   localparam corner_idx_type TRI_CORNER [NUM_TRIS][TRI_EDGES] =
      '{'{CORNER_A, CORNER_B, CORNER_C}, '{CORNER_A, CORNER_D, CORNER_C}};

   typedef logic signed [COORD_BITS-1:0] coord_type;
   typedef logic signed [DIFF_W-1:0]     diff_type;
   typedef logic signed [PROD_W-1:0]     prod_type;
   typedef logic signed [ORI_W-1:0]      ori_type;

   // Sign of an orientation value; both clear means zero.
   typedef struct packed {
      logic pos;
      logic neg;
   } sign_type;

endpackage

/* src/quad_overlap_test_unit.sv */
// Quad overlap test unit: a four-stage pipeline that reports whether two
// quadrilaterals overlap. Depends on qot_pkg.
//
// Usage
//   req channel: one item carries the four corners of each quad. Each
//   corner packs x in the high half and y in the low half, both two's
//   complement. An item is taken when req_tvalid and req_tready are high.
//   rsp channel: one item per request, in order, holding the overlap flag.
//   Each quad is split along its a-c diagonal; edges must cross strictly or
//   a triangle must lie strictly inside another, so touching does not count.
// Throughput
//   One item is accepted every cycle unless a stall has filled the stages;
//   the stages are coordinate differences, the 17x17 products, the
//   orientation subtract and sign, and the final crossing and containment
//   logic.
// Reset and stalls
//   Synchronous reset empties every stage. When rsp_tready is low the
//   stages still fill any empty slot behind the waiting result; once all
//   four hold an item, req_tready drops and nothing is lost or repeated.
module quad_overlap_test_unit (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   // Fields from bit 0 up: quad1_corner_a, quad1_corner_b, quad1_corner_c,
   // quad1_corner_d, quad2_corner_a, quad2_corner_b, quad2_corner_c,
   // quad2_corner_d (32 bits each).
   input  logic [qot_pkg::REQ_W-1:0] req_tdata,
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   // Fields from bit 0 up: overlap (1 bit), then zero fill.
   output logic [qot_pkg::RSP_W-1:0] rsp_tdata
);

   localparam int NL = qot_pkg::NUM_LINES;
   localparam int NC = qot_pkg::NUM_CORNERS;

   // Stage enables: a stage loads when it is empty or its successor loads.
   logic en1, en2, en3, en4;
   logic v1_ff, v2_ff, v3_ff, v4_ff;

   qot_pkg::coord_type q1x [NC];
   qot_pkg::coord_type q1y [NC];
   qot_pkg::coord_type q2x [NC];
   qot_pkg::coord_type q2y [NC];

   // Stage 1: edge vectors of each quad's lines, and vectors from each line
   // start to the corners of the other quad.
   qot_pkg::diff_type e1x_in [NL], e1y_in [NL], e2x_in [NL], e2y_in [NL];
   qot_pkg::diff_type e1x_ff [NL], e1y_ff [NL], e2x_ff [NL], e2y_ff [NL];
   qot_pkg::diff_type d1x_in [NL][NC], d1y_in [NL][NC];
   qot_pkg::diff_type d2x_in [NL][NC], d2y_in [NL][NC];
   qot_pkg::diff_type d1x_ff [NL][NC], d1y_ff [NL][NC];
   qot_pkg::diff_type d2x_ff [NL][NC], d2y_ff [NL][NC];

   // Stage 2: the two products of each cross product.
   qot_pkg::prod_type m1a_in [NL][NC], m1b_in [NL][NC];
   qot_pkg::prod_type m2a_in [NL][NC], m2b_in [NL][NC];
   qot_pkg::prod_type m1a_ff [NL][NC], m1b_ff [NL][NC];
   qot_pkg::prod_type m2a_ff [NL][NC], m2b_ff [NL][NC];

   // Stage 3: orientation signs. s1 holds quad2 corners against quad1
   // lines, s2 holds quad1 corners against quad2 lines.
   qot_pkg::sign_type s1_in [NL][NC], s2_in [NL][NC];
   qot_pkg::sign_type s1_ff [NL][NC], s2_ff [NL][NC];

   // Stage 4: result.
   logic overlap_in, overlap_ff;

   function automatic logic opposite(qot_pkg::sign_type a, qot_pkg::sign_type b);
      return (a.pos && b.neg) || (a.neg && b.pos);
   endfunction

   assign en4        = !v4_ff || rsp_tready;
   assign en3        = !v3_ff || en4;
   assign en2        = !v2_ff || en3;
   assign en1        = !v1_ff || en2;
   assign req_tready = en1;
   assign rsp_tvalid = v4_ff;
   assign rsp_tdata  = {{(qot_pkg::RSP_W-1){1'b0}}, overlap_ff};

   always_comb begin
      for (int c = 0; c < NC; c++) begin
         q1x[c] = req_tdata[c*qot_pkg::FIELD_W + qot_pkg::COORD_BITS +: qot_pkg::COORD_BITS];
         q1y[c] = req_tdata[c*qot_pkg::FIELD_W +: qot_pkg::COORD_BITS];
         q2x[c] = req_tdata[(c+NC)*qot_pkg::FIELD_W + qot_pkg::COORD_BITS +:
                            qot_pkg::COORD_BITS];
         q2y[c] = req_tdata[(c+NC)*qot_pkg::FIELD_W +: qot_pkg::COORD_BITS];
      end
      for (int l = 0; l < NL; l++) begin
         e1x_in[l] = qot_pkg::DIFF_W'(q1x[qot_pkg::LINE_TO[l]])
                   - qot_pkg::DIFF_W'(q1x[qot_pkg::LINE_FROM[l]]);
         e1y_in[l] = qot_pkg::DIFF_W'(q1y[qot_pkg::LINE_TO[l]])
                   - qot_pkg::DIFF_W'(q1y[qot_pkg::LINE_FROM[l]]);
         e2x_in[l] = qot_pkg::DIFF_W'(q2x[qot_pkg::LINE_TO[l]])
                   - qot_pkg::DIFF_W'(q2x[qot_pkg::LINE_FROM[l]]);
         e2y_in[l] = qot_pkg::DIFF_W'(q2y[qot_pkg::LINE_TO[l]])
                   - qot_pkg::DIFF_W'(q2y[qot_pkg::LINE_FROM[l]]);
         for (int p = 0; p < NC; p++) begin
            d1x_in[l][p] = qot_pkg::DIFF_W'(q2x[p])
                         - qot_pkg::DIFF_W'(q1x[qot_pkg::LINE_FROM[l]]);
            d1y_in[l][p] = qot_pkg::DIFF_W'(q2y[p])
                         - qot_pkg::DIFF_W'(q1y[qot_pkg::LINE_FROM[l]]);
            d2x_in[l][p] = qot_pkg::DIFF_W'(q1x[p])
                         - qot_pkg::DIFF_W'(q2x[qot_pkg::LINE_FROM[l]]);
            d2y_in[l][p] = qot_pkg::DIFF_W'(q1y[p])
                         - qot_pkg::DIFF_W'(q2y[qot_pkg::LINE_FROM[l]]);
         end
      end
   end

   always_comb begin
      for (int l = 0; l < NL; l++) begin
         for (int p = 0; p < NC; p++) begin
            m1a_in[l][p] = qot_pkg::PROD_W'(e1x_ff[l]) * qot_pkg::PROD_W'(d1y_ff[l][p]);
            m1b_in[l][p] = qot_pkg::PROD_W'(e1y_ff[l]) * qot_pkg::PROD_W'(d1x_ff[l][p]);
            m2a_in[l][p] = qot_pkg::PROD_W'(e2x_ff[l]) * qot_pkg::PROD_W'(d2y_ff[l][p]);
            m2b_in[l][p] = qot_pkg::PROD_W'(e2y_ff[l]) * qot_pkg::PROD_W'(d2x_ff[l][p]);
         end
      end
   end

   always_comb begin
      qot_pkg::ori_type o1, o2;
      for (int l = 0; l < NL; l++) begin
         for (int p = 0; p < NC; p++) begin
            o1 = qot_pkg::ORI_W'(m1a_ff[l][p]) - qot_pkg::ORI_W'(m1b_ff[l][p]);
            o2 = qot_pkg::ORI_W'(m2a_ff[l][p]) - qot_pkg::ORI_W'(m2b_ff[l][p]);
            s1_in[l][p].neg = o1[qot_pkg::ORI_W-1];
            s1_in[l][p].pos = !o1[qot_pkg::ORI_W-1] && (o1 != '0);
            s2_in[l][p].neg = o2[qot_pkg::ORI_W-1];
            s2_in[l][p].pos = !o2[qot_pkg::ORI_W-1] && (o2 != '0);
         end
      end
   end

   // The cross test is symmetric in the end points of either segment, so
   // each pair of the five quad lines is tested once.
   always_comb begin
      logic cross_any, contain_any;
      logic all_pos, all_neg, t_in_u, u_in_t;
      cross_any   = 1'b0;
      contain_any = 1'b0;
      for (int i = 0; i < NL; i++) begin
         for (int j = 0; j < NL; j++) begin
            if (opposite(s2_ff[j][qot_pkg::LINE_FROM[i]], s2_ff[j][qot_pkg::LINE_TO[i]]) &&
                opposite(s1_ff[i][qot_pkg::LINE_FROM[j]], s1_ff[i][qot_pkg::LINE_TO[j]])) begin
               cross_any = 1'b1;
            end
         end
      end
      for (int ti = 0; ti < qot_pkg::NUM_TRIS; ti++) begin
         for (int uj = 0; uj < qot_pkg::NUM_TRIS; uj++) begin
            // Corners of the first quad's triangle inside the second's.
            t_in_u = 1'b1;
            for (int k = 0; k < qot_pkg::TRI_EDGES; k++) begin
               all_pos = 1'b1;
               all_neg = 1'b1;
               for (int e = 0; e < qot_pkg::TRI_EDGES; e++) begin
                  all_pos &= s2_ff[qot_pkg::TRI_LINE[uj][e]][qot_pkg::TRI_CORNER[ti][k]].pos;
                  all_neg &= s2_ff[qot_pkg::TRI_LINE[uj][e]][qot_pkg::TRI_CORNER[ti][k]].neg;
               end
               t_in_u &= all_pos || all_neg;
            end
            // Corners of the second quad's triangle inside the first's.
            u_in_t = 1'b1;
            for (int k = 0; k < qot_pkg::TRI_EDGES; k++) begin
               all_pos = 1'b1;
               all_neg = 1'b1;
               for (int e = 0; e < qot_pkg::TRI_EDGES; e++) begin
                  all_pos &= s1_ff[qot_pkg::TRI_LINE[ti][e]][qot_pkg::TRI_CORNER[uj][k]].pos;
                  all_neg &= s1_ff[qot_pkg::TRI_LINE[ti][e]][qot_pkg::TRI_CORNER[uj][k]].neg;
               end
               u_in_t &= all_pos || all_neg;
            end
            contain_any |= t_in_u || u_in_t;
         end
      end
      overlap_in = cross_any || contain_any;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         if (en1) begin
            v1_ff <= req_tvalid;
         end
         if (en2) begin
            v2_ff <= v1_ff;
         end
         if (en3) begin
            v3_ff <= v2_ff;
         end
         if (en4) begin
            v4_ff <= v3_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         e1x_ff <= e1x_in;
         e1y_ff <= e1y_in;
         e2x_ff <= e2x_in;
         e2y_ff <= e2y_in;
         d1x_ff <= d1x_in;
         d1y_ff <= d1y_in;
         d2x_ff <= d2x_in;
         d2y_ff <= d2y_in;
      end
      if (en2) begin
         m1a_ff <= m1a_in;
         m1b_ff <= m1b_in;
         m2a_ff <= m2a_in;
         m2b_ff <= m2b_in;
      end
      if (en3) begin
         s1_ff <= s1_in;
         s2_ff <= s2_in;
      end
      if (en4) begin
         overlap_ff <= overlap_in;
      end
   end

endmodule

/* bench/quad_overlap_test_unit_tb.sv */
// Self-checking bench for quad_overlap_test_unit: directed corner cases, then random quad pairs
// under random request bursts and response back-pressure, each result checked against the row's
// typed value or the predictor. Depends on qot_pkg and quad_overlap_test_unit.
module quad_overlap_test_unit_tb;

   localparam int NUM_RANDOM  = 950;
   localparam int IDLE_LIMIT  = 2000;
   localparam int TAIL_CYCLES = 16;
   localparam int MAX_REPORTS = 20;
   localparam int LO = -32768;
   localparam int HI = 32767;

   // Whether a directed row carries a hand-written result or uses the predictor.
   localparam bit TYPED     = 1'b1;
   localparam bit PREDICTED = 1'b0;

   // Receiver behaviors.
   localparam int READY_ALWAYS   = 0;
   localparam int READY_RANDOM   = 1;
   localparam int READY_PERIODIC = 2;
   localparam int READY_BURSTY   = 3;

   // Random item shapes.
   localparam int SHAPE_NOISE_END  = 3;
   localparam int SHAPE_LOCAL_END  = 12;
   localparam int SHAPE_SHARED_END = 17;

   typedef struct packed {
      longint x;
      longint y;
   } point_type;
   typedef point_type [2:0] tri_type;
   typedef point_type [3:0] quad_type;

   typedef struct packed {
      logic [qot_pkg::REQ_W-1:0] item;
      bit                        typed;
      bit                        overlap;
   } stim_row_type;

   logic                      clock;
   logic                      reset;
   logic                      req_tvalid;
   logic                      req_tready;
   logic [qot_pkg::REQ_W-1:0] req_tdata;
   logic                      rsp_tvalid;
   logic                      rsp_tready;
   logic [qot_pkg::RSP_W-1:0] rsp_tdata;

   bit           item_typed;
   bit           item_typed_overlap;
   bit           overlap_expected [$];
   stim_row_type stim_rows [$];
   int           mismatch_count;
   int           idle_cycles;

   quad_overlap_test_unit DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // ---------------------------------------------------------------- predictor

   function automatic point_type unpack_point(logic [qot_pkg::FIELD_W-1:0] word);
      qot_pkg::coord_type cx;
      qot_pkg::coord_type cy;
      point_type          p;
      cx = word[2*qot_pkg::COORD_BITS-1:qot_pkg::COORD_BITS];
      cy = word[qot_pkg::COORD_BITS-1:0];
      p.x = longint'(cx);
      p.y = longint'(cy);
      return p;
   endfunction

   function automatic bit opposite_signs(longint a, longint b);
      return (a > 0 && b < 0) || (a < 0 && b > 0);
   endfunction

   function automatic bit edges_cross(point_type p1, point_type q1,
                                      point_type p2, point_type q2);
      longint dx1, dy1, dx2, dy2, s1, s2, s3, s4;
      dx2 = p2.x - q2.x;
      dy2 = p2.y - q2.y;
      dx1 = p1.x - q1.x;
      dy1 = p1.y - q1.y;
      s1 = dx2 * (p1.y - p2.y) + dy2 * (p2.x - p1.x);
      s2 = dx2 * (q1.y - p2.y) + dy2 * (p2.x - q1.x);
      s3 = dx1 * (p2.y - p1.y) + dy1 * (p1.x - p2.x);
      s4 = dx1 * (q2.y - p1.y) + dy1 * (p1.x - q2.x);
      return opposite_signs(s3, s4) && opposite_signs(s1, s2);
   endfunction

   function automatic longint turn_value(point_type from_pt, point_type to_pt,
                                         point_type probe);
      return (to_pt.x - from_pt.x) * (probe.y - to_pt.y) -
             (to_pt.y - from_pt.y) * (probe.x - to_pt.x);
   endfunction

   function automatic bit strictly_within(point_type p, tri_type u);
      longint k0, k1, k2;
      k0 = turn_value(u[0], u[1], p);
      k1 = turn_value(u[1], u[2], p);
      k2 = turn_value(u[2], u[0], p);
      return (k0 > 0 && k1 > 0 && k2 > 0) || (k0 < 0 && k1 < 0 && k2 < 0);
   endfunction

   function automatic bit triangles_overlap(tri_type t, tri_type u);
      bit hit;
      bit t_in_u;
      bit u_in_t;
      int i, j;
      hit = 1'b0;
      t_in_u = 1'b1;
      u_in_t = 1'b1;
      for (i = 0; i < 3; i++) begin
         for (j = 0; j < 3; j++) begin
            if (edges_cross(t[i], t[(i+1)%3], u[j], u[(j+1)%3]))
               hit = 1'b1;
         end
         t_in_u = t_in_u & strictly_within(t[i], u);
         u_in_t = u_in_t & strictly_within(u[i], t);
      end
      return hit || t_in_u || u_in_t;
   endfunction

   // Triangle (a,b,c) or, for the second half, triangle (a,d,c).
   function automatic tri_type quad_half(quad_type q, bit second);
      tri_type t;
      t[0] = q[qot_pkg::CORNER_A];
      t[1] = second ? q[qot_pkg::CORNER_D] : q[qot_pkg::CORNER_B];
      t[2] = q[qot_pkg::CORNER_C];
      return t;
   endfunction

   function automatic bit predict_overlap(logic [qot_pkg::REQ_W-1:0] item);
      quad_type first_quad;
      quad_type second_quad;
      bit       hit;
      int       k, i, j;
      hit = 1'b0;
      for (k = 0; k < qot_pkg::NUM_CORNERS; k++) begin
         first_quad[k]  = unpack_point(item[k*qot_pkg::FIELD_W +: qot_pkg::FIELD_W]);
         second_quad[k] = unpack_point(item[(qot_pkg::NUM_CORNERS+k)*qot_pkg::FIELD_W +:
                                            qot_pkg::FIELD_W]);
      end
      for (i = 0; i < 2; i++)
         for (j = 0; j < 2; j++)
            if (triangles_overlap(quad_half(first_quad, i[0]),
                                  quad_half(second_quad, j[0])))
               hit = 1'b1;
      return hit;
   endfunction

   // ---------------------------------------------------------------- stimulus

   function automatic logic [qot_pkg::FIELD_W-1:0] xy(int x, int y);
      logic [qot_pkg::COORD_BITS-1:0] xb;
      logic [qot_pkg::COORD_BITS-1:0] yb;
      xb = x[qot_pkg::COORD_BITS-1:0];
      yb = y[qot_pkg::COORD_BITS-1:0];
      return {xb, yb};
   endfunction

   function automatic stim_row_type directed_row(bit typed, bit overlap,
         logic [qot_pkg::FIELD_W-1:0] a1, logic [qot_pkg::FIELD_W-1:0] b1,
         logic [qot_pkg::FIELD_W-1:0] c1, logic [qot_pkg::FIELD_W-1:0] d1,
         logic [qot_pkg::FIELD_W-1:0] a2, logic [qot_pkg::FIELD_W-1:0] b2,
         logic [qot_pkg::FIELD_W-1:0] c2, logic [qot_pkg::FIELD_W-1:0] d2);
      stim_row_type row;
      row.item    = {d2, c2, b2, a2, d1, c1, b1, a1};
      row.typed   = typed;
      row.overlap = overlap;
      return row;
   endfunction

   // Coordinates are kept as x,y pairs in c[2k], c[2k+1]; corners 0-3 are the first quad.
   function automatic logic [qot_pkg::REQ_W-1:0] random_quad_pair();
      logic [qot_pkg::REQ_W-1:0] item;
      int c [16];
      int shape, bx, by, ox, oy, k, j, r;
      shape = $urandom_range(0, 19);
      bx = int'($urandom_range(0, 64000)) - 32000;
      by = int'($urandom_range(0, 64000)) - 32000;
      ox = int'($urandom_range(0, 24)) - 12;
      oy = int'($urandom_range(0, 24)) - 12;
      for (k = 0; k < 8; k++) begin
         c[2*k]   = bx + (k >= 4 ? ox : 0) + int'($urandom_range(0, 16)) - 8;
         c[2*k+1] = by + (k >= 4 ? oy : 0) + int'($urandom_range(0, 16)) - 8;
      end
      if (shape >= SHAPE_LOCAL_END && shape < SHAPE_SHARED_END) begin
         // Second quad reuses corners of the first or lines up with them.
         for (k = 4; k < 8; k++) begin
            j = $urandom_range(0, 3);
            r = $urandom_range(0, 3);
            case ($urandom_range(0, 3))
               0: begin
                  c[2*k]   = c[2*j];
                  c[2*k+1] = c[2*j+1];
               end
               1: begin
                  c[2*k]   = 2 * c[2*j] - c[2*r];
                  c[2*k+1] = 2 * c[2*j+1] - c[2*r+1];
               end
               default: ;
            endcase
         end
      end else if (shape >= SHAPE_SHARED_END) begin
         for (k = 0; k < 16; k++) begin
            case ($urandom_range(0, 6))
               0: c[k] = LO;
               1: c[k] = LO + 1;
               2: c[k] = -1;
               3: c[k] = 0;
               4: c[k] = 1;
               5: c[k] = HI - 1;
               default: c[k] = HI;
            endcase
         end
      end
      for (k = 0; k < 8; k++) begin
         if (shape < SHAPE_NOISE_END)
            item[k*qot_pkg::FIELD_W +: qot_pkg::FIELD_W] = $urandom();
         else
            item[k*qot_pkg::FIELD_W +: qot_pkg::FIELD_W] = xy(c[2*k], c[2*k+1]);
      end
      return item;
   endfunction

   // ---------------------------------------------------------------- clock and reset

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      reset = 1'b1;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
   end

   // ---------------------------------------------------------------- request side

   initial begin : drive_requests
      stim_row_type row;
      int total, burst_left, gap, n;
      req_tvalid = 1'b0;
      req_tdata = '0;
      item_typed = PREDICTED;
      item_typed_overlap = 1'b0;

      stim_rows.push_back(directed_row(TYPED, 1'b0, xy(0, 0), xy(0, 0), xy(0, 0), xy(0, 0),
                                       xy(0, 0), xy(0, 0), xy(0, 0), xy(0, 0)));
      stim_rows.push_back(directed_row(TYPED, 1'b0, '1, '1, '1, '1, '1, '1, '1, '1));
      // Full-width thin bars crossing at the origin.
      stim_rows.push_back(directed_row(TYPED, 1'b1,
         xy(LO, -1), xy(HI, -1), xy(HI, 1), xy(LO, 1),
         xy(-1, LO), xy(1, LO), xy(1, HI), xy(-1, HI)));
      stim_rows.push_back(directed_row(TYPED, 1'b0,
         xy(LO, LO), xy(LO+10, LO), xy(LO+10, LO+10), xy(LO, LO+10),
         xy(HI-10, HI-10), xy(HI, HI-10), xy(HI, HI), xy(HI-10, HI)));
      stim_rows.push_back(directed_row(PREDICTED, 1'b0,
         xy(LO, LO), xy(HI, LO), xy(HI, HI), xy(LO, HI),
         xy(LO, LO), xy(HI, LO), xy(HI, HI), xy(LO, HI)));
      stim_rows.push_back(directed_row(PREDICTED, 1'b0,
         xy(HI, LO), xy(LO, HI), xy(LO, LO), xy(HI, HI),
         xy(0, LO), xy(LO, 0), xy(0, HI), xy(HI, 0)));
      stim_rows.push_back(directed_row(PREDICTED, 1'b0,
         32'h7FFF_8000, 32'h8000_7FFF, 32'h0000_FFFF, 32'hFFFF_0000,
         32'h8000_8000, 32'h7FFF_7FFF, 32'h0001_8001, 32'h8001_0001));
      // Identical squares.
      stim_rows.push_back(directed_row(PREDICTED, 1'b0,
         xy(0, 0), xy(10, 0), xy(10, 10), xy(0, 10),
         xy(0, 0), xy(10, 0), xy(10, 10), xy(0, 10)));
      // Squares touching at one corner, then along a whole edge.
      stim_rows.push_back(directed_row(PREDICTED, 1'b0,
         xy(0, 0), xy(10, 0), xy(10, 10), xy(0, 10),
         xy(10, 10), xy(20, 10), xy(20, 20), xy(10, 20)));
      stim_rows.push_back(directed_row(PREDICTED, 1'b0,
         xy(0, 0), xy(10, 0), xy(10, 10), xy(0, 10),
         xy(10, 0), xy(20, 0), xy(20, 10), xy(10, 10)));
      // Edges running along each other for part of their length.
      stim_rows.push_back(directed_row(PREDICTED, 1'b0,
         xy(0, 0), xy(10, 0), xy(10, 10), xy(0, 10),
         xy(5, 0), xy(15, 0), xy(15, -10), xy(5, -10)));
      // Small square strictly inside a large one, both ways round.
      stim_rows.push_back(directed_row(PREDICTED, 1'b0,
         xy(-100, -100), xy(100, -100), xy(100, 100), xy(-100, 100),
         xy(10, -5), xy(20, -5), xy(20, 5), xy(10, 5)));
      stim_rows.push_back(directed_row(PREDICTED, 1'b0,
         xy(-5, 10), xy(5, 10), xy(5, 20), xy(-5, 20),
         xy(-100, -100), xy(100, -100), xy(100, 100), xy(-100, 100)));
      stim_rows.push_back(directed_row(PREDICTED, 1'b0,
         xy(0, 0), xy(10, 0), xy(10, 10), xy(0, 10),
         xy(5, 5), xy(15, 5), xy(15, 15), xy(5, 15)));
      // Degenerate first quad: a segment across the square, then one lying on its edge.
      stim_rows.push_back(directed_row(PREDICTED, 1'b0,
         xy(-5, 5), xy(-5, 5), xy(15, 5), xy(15, 5),
         xy(0, 0), xy(10, 0), xy(10, 10), xy(0, 10)));
      stim_rows.push_back(directed_row(PREDICTED, 1'b0,
         xy(-5, 0), xy(0, 0), xy(5, 0), xy(15, 0),
         xy(0, 0), xy(10, 0), xy(10, 10), xy(0, 10)));
      // Self-crossing quad.
      stim_rows.push_back(directed_row(PREDICTED, 1'b0,
         xy(0, 0), xy(10, 10), xy(10, 0), xy(0, 10),
         xy(4, 2), xy(6, 2), xy(6, 4), xy(4, 4)));
      // Inner square touching the outer left edge from inside.
      stim_rows.push_back(directed_row(PREDICTED, 1'b0,
         xy(0, 0), xy(10, 0), xy(10, 10), xy(0, 10),
         xy(0, 2), xy(4, 2), xy(4, 6), xy(0, 6)));
      // Only the first quad's (a,d,c) half can meet the second quad here.
      stim_rows.push_back(directed_row(PREDICTED, 1'b0,
         xy(0, 0), xy(10, 0), xy(10, 10), xy(0, 10),
         xy(1, 7), xy(2, 7), xy(2, 8), xy(1, 8)));

      wait (!reset);
      @(negedge clock);
      burst_left = 0;
      total = stim_rows.size() + NUM_RANDOM;
      for (n = 0; n < total; n++) begin
         if (burst_left == 0) begin
            if ($urandom_range(0, 7) == 0) begin
               burst_left = $urandom_range(40, 120);
               gap = 0;
            end else begin
               burst_left = $urandom_range(1, 16);
               gap = $urandom_range(0, 8);
            end
            if (gap != 0) begin
               req_tvalid = 1'b0;
               repeat (gap) @(negedge clock);
            end
         end
         if (n < stim_rows.size()) begin
            row = stim_rows[n];
         end else begin
            row.item    = random_quad_pair();
            row.typed   = PREDICTED;
            row.overlap = 1'b0;
         end
         req_tdata = row.item;
         item_typed = row.typed;
         item_typed_overlap = row.overlap;
         req_tvalid = 1'b1;
         @(posedge clock);
         while (!req_tready) @(posedge clock);
         @(negedge clock);
         burst_left--;
      end
      req_tvalid = 1'b0;

      while (overlap_expected.size() != 0) @(negedge clock);
      repeat (TAIL_CYCLES) @(negedge clock);
      if (mismatch_count == 0 && overlap_expected.size() == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

   // ---------------------------------------------------------------- response side

   initial begin : drive_ready
      int mode, span, period, phase, stall_left;
      rsp_tready = 1'b0;
      stall_left = 0;
      phase = 0;
      forever begin
         mode = $urandom_range(READY_ALWAYS, READY_BURSTY);
         span = $urandom_range(32, 160);
         period = $urandom_range(2, 8);
         repeat (span) begin
            @(negedge clock);
            phase++;
            case (mode)
               READY_ALWAYS: rsp_tready = 1'b1;
               READY_RANDOM: rsp_tready = 1'($urandom_range(0, 1));
               READY_PERIODIC: rsp_tready = (phase % period) == 0;
               default: begin
                  if (stall_left > 0) begin
                     rsp_tready = 1'b0;
                     stall_left--;
                  end else begin
                     rsp_tready = 1'b1;
                     if ($urandom_range(0, 5) == 0)
                        stall_left = $urandom_range(4, 24);
                  end
               end
            endcase
         end
      end
   end

   // ---------------------------------------------------------------- checking

   initial begin
      mismatch_count = 0;
      idle_cycles = 0;
   end

   always @(posedge clock) begin : check_results
      bit                        want;
      logic [qot_pkg::RSP_W-1:0] want_word;
      if (!reset) begin
         if (req_tvalid && req_tready)
            overlap_expected.push_back(item_typed ? item_typed_overlap
                                                  : predict_overlap(req_tdata));
         if (rsp_tvalid && rsp_tready) begin
            if (overlap_expected.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= MAX_REPORTS)
                  $display("%0t: result with no item outstanding, got %h", $time, rsp_tdata);
            end else begin
               want = overlap_expected.pop_front();
               want_word = {{(qot_pkg::RSP_W-1){1'b0}}, want};
               if (rsp_tdata !== want_word) begin
                  mismatch_count++;
                  if (mismatch_count <= MAX_REPORTS)
                     $display("%0t: overlap mismatch, expected %h, got %h",
                              $time, want_word, rsp_tdata);
               end
            end
         end
         // Watchdog: give up when neither side has moved an item for too long.
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
               $display("%0t: no item moved for %0d cycles", $time, IDLE_LIMIT);
               $display("*** FAILED ***");
               $finish;
            end
         end
      end
   end

endmodule

/* sim.f */
src/qot_pkg.sv
src/quad_overlap_test_unit.sv
bench/quad_overlap_test_unit_tb.sv
